// File: sv/vdg_scanline_pixel_generator_top_defines.svh
// Assertion macros shared by the scanline pixel generator RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef VDG_SCANLINE_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define VDG_SCANLINE_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VDG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VDG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdg: next-cycle check failed");

`endif

// File: sv/vdg_pkg.sv
// Shared types, constants, mode codes and the character font for the VDG.
// No dependencies; imported by every module of the block.
package vdg_pkg;

  // field widths
  localparam int LINE_W      = 9;
  localparam int COL_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 4;
  localparam int ADDR_W      = 16;
  localparam int NUM_PIX     = 8;
  localparam int RL_W        = 4;
  localparam int TR_W        = 5;
  localparam int LINE_NEXT_W = 8;
  localparam int MODE_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam int IN_FIELDS_W  = LINE_W + COL_W + BYTE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = NUM_PIX * PIX_W + ADDR_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // frame geometry
  localparam int GROUPS_PER_LINE = 32;
  localparam int ROWS_PER_CHAR   = 12;
  localparam int VISIBLE_LINES   = 192;
  localparam int VBLANK_END      = 224;
  localparam int NTSC_RELOAD     = 261;
  localparam int PAL_RELOAD      = 311;
  localparam logic [ADDR_W-1:0] SCREEN_BASE = 16'h8000;

  // glyph rows 3..9 of the 12-line cell carry the character pattern
  localparam int GLYPH_ROWS      = 7;
  localparam int GLYPH_W         = 6;
  localparam int GLYPH_FIRST_ROW = 3;
  localparam int GLYPH_LAST_ROW  = 9;

  // video byte bits in text modes
  localparam int SEMI_BIT = 6;
  localparam int INV_BIT  = 7;

  // n/3 for n < 256 as (n * 171) >> 9
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [PIX_W-1:0] TEXT_COLOURS   [4] = '{4'd0, 4'd1, 4'd0, 4'd8};
  localparam logic [PIX_W-1:0] BITMAP_COLOURS [4] = '{4'd0, 4'd1, 4'd0, 4'd5};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIDEO_MODE = 2'd0,
    CFG_COLOUR_SET = 2'd1,
    CFG_PAL_TIMING = 2'd2
  } cfg_idx_t;

  // bitmap mode codes (even codes are text)
  localparam logic [MODE_W-1:0] MODE_BM4_16  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BM2_16A = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BM4_32A = 4'd5;
  localparam logic [MODE_W-1:0] MODE_BM2_16B = 4'd7;
  localparam logic [MODE_W-1:0] MODE_BM4_32B = 4'd9;
  localparam logic [MODE_W-1:0] MODE_BM2_16C = 4'd11;
  localparam logic [MODE_W-1:0] MODE_BM4_32C = 4'd13;
  localparam logic [MODE_W-1:0] MODE_BM2_32  = 4'd15;

  typedef logic [GLYPH_ROWS-1:0][GLYPH_W-1:0] glyph_t;

  // one classified group on its way from front to back
  typedef struct packed {
    logic                    visible;
    logic                    reload;
    logic                    vblank;
    logic [MODE_W-1:0]       mode;
    logic                    cs;
    logic [COL_W-1:0]        col;
    logic [BYTE_W-1:0]       vbyte;
    logic [RL_W-1:0]         row_line;
    logic [TR_W-1:0]         text_row_next;
    logic [LINE_NEXT_W-1:0]  line_next;
  } vdg_item_t;

  // first pattern row in the highest slice
  function automatic glyph_t font_glyph(input logic [5:0] chr);
    glyph_t g;
    case (chr)
      6'd0:  g = {6'h1c, 6'h22, 6'h02, 6'h1a, 6'h2a, 6'h2a, 6'h1c};
      6'd1:  g = {6'h08, 6'h14, 6'h22, 6'h22, 6'h3e, 6'h22, 6'h22};
      6'd2:  g = {6'h3c, 6'h12, 6'h12, 6'h1c, 6'h12, 6'h12, 6'h3c};
      6'd3:  g = {6'h1c, 6'h22, 6'h20, 6'h20, 6'h20, 6'h22, 6'h1c};
      6'd4:  g = {6'h3c, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h3c};
      6'd5:  g = {6'h3e, 6'h20, 6'h20, 6'h3c, 6'h20, 6'h20, 6'h3e};
      6'd6:  g = {6'h3e, 6'h20, 6'h20, 6'h3c, 6'h20, 6'h20, 6'h20};
      6'd7:  g = {6'h1e, 6'h20, 6'h20, 6'h26, 6'h22, 6'h22, 6'h1e};
      6'd8:  g = {6'h22, 6'h22, 6'h22, 6'h3e, 6'h22, 6'h22, 6'h22};
      6'd9:  g = {6'h1c, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h1c};
      6'd10: g = {6'h02, 6'h02, 6'h02, 6'h02, 6'h22, 6'h22, 6'h1c};
      6'd11: g = {6'h22, 6'h24, 6'h28, 6'h30, 6'h28, 6'h24, 6'h22};
      6'd12: g = {6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h3e};
      6'd13: g = {6'h22, 6'h36, 6'h2a, 6'h2a, 6'h22, 6'h22, 6'h22};
      6'd14: g = {6'h22, 6'h32, 6'h2a, 6'h26, 6'h22, 6'h22, 6'h22};
      6'd15: g = {6'h3e, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h3e};
      6'd16: g = {6'h3c, 6'h22, 6'h22, 6'h3c, 6'h20, 6'h20, 6'h20};
      6'd17: g = {6'h1c, 6'h22, 6'h22, 6'h22, 6'h2a, 6'h24, 6'h1a};
      6'd18: g = {6'h3c, 6'h22, 6'h22, 6'h3c, 6'h28, 6'h24, 6'h22};
      6'd19: g = {6'h1c, 6'h22, 6'h10, 6'h08, 6'h04, 6'h22, 6'h1c};
      6'd20: g = {6'h3e, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08};
      6'd21: g = {6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1c};
      6'd22: g = {6'h22, 6'h22, 6'h22, 6'h14, 6'h14, 6'h08, 6'h08};
      6'd23: g = {6'h22, 6'h22, 6'h22, 6'h2a, 6'h2a, 6'h36, 6'h22};
      6'd24: g = {6'h22, 6'h22, 6'h14, 6'h08, 6'h14, 6'h22, 6'h22};
      6'd25: g = {6'h22, 6'h22, 6'h14, 6'h08, 6'h08, 6'h08, 6'h08};
      6'd26: g = {6'h3e, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h3e};
      6'd27: g = {6'h38, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h38};
      6'd28: g = {6'h20, 6'h20, 6'h10, 6'h08, 6'h04, 6'h02, 6'h02};
      6'd29: g = {6'h0e, 6'h02, 6'h02, 6'h02, 6'h02, 6'h02, 6'h0e};
      6'd30: g = {6'h08, 6'h1c, 6'h2a, 6'h08, 6'h08, 6'h08, 6'h08};
      6'd31: g = {6'h00, 6'h08, 6'h10, 6'h3e, 6'h10, 6'h08, 6'h00};
      6'd32: g = {6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00};
      6'd33: g = {6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h00, 6'h08};
      6'd34: g = {6'h14, 6'h14, 6'h14, 6'h00, 6'h00, 6'h00, 6'h00};
      6'd35: g = {6'h14, 6'h14, 6'h36, 6'h00, 6'h36, 6'h14, 6'h14};
      6'd36: g = {6'h08, 6'h1e, 6'h20, 6'h1c, 6'h02, 6'h3c, 6'h08};
      6'd37: g = {6'h32, 6'h32, 6'h04, 6'h08, 6'h10, 6'h26, 6'h26};
      6'd38: g = {6'h10, 6'h28, 6'h28, 6'h10, 6'h2a, 6'h24, 6'h1a};
      6'd39: g = {6'h18, 6'h18, 6'h18, 6'h00, 6'h00, 6'h00, 6'h00};
      6'd40: g = {6'h08, 6'h10, 6'h20, 6'h20, 6'h20, 6'h10, 6'h08};
      6'd41: g = {6'h08, 6'h04, 6'h02, 6'h02, 6'h02, 6'h04, 6'h08};
      6'd42: g = {6'h00, 6'h08, 6'h1c, 6'h3e, 6'h1c, 6'h08, 6'h00};
      6'd43: g = {6'h00, 6'h08, 6'h08, 6'h3e, 6'h08, 6'h08, 6'h00};
      6'd44: g = {6'h00, 6'h00, 6'h00, 6'h30, 6'h30, 6'h10, 6'h20};
      6'd45: g = {6'h00, 6'h00, 6'h00, 6'h3e, 6'h00, 6'h00, 6'h00};
      6'd46: g = {6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h30, 6'h30};
      6'd47: g = {6'h02, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h20};
      6'd48: g = {6'h18, 6'h24, 6'h24, 6'h24, 6'h24, 6'h24, 6'h18};
      6'd49: g = {6'h08, 6'h18, 6'h08, 6'h08, 6'h08, 6'h08, 6'h1c};
      6'd50: g = {6'h1c, 6'h22, 6'h02, 6'h1c, 6'h20, 6'h20, 6'h3e};
      6'd51: g = {6'h1c, 6'h22, 6'h02, 6'h0c, 6'h02, 6'h22, 6'h1c};
      6'd52: g = {6'h04, 6'h0c, 6'h14, 6'h3e, 6'h04, 6'h04, 6'h04};
      6'd53: g = {6'h3e, 6'h20, 6'h3c, 6'h02, 6'h02, 6'h22, 6'h1c};
      6'd54: g = {6'h1c, 6'h20, 6'h20, 6'h3c, 6'h22, 6'h22, 6'h1c};
      6'd55: g = {6'h3e, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h20};
      6'd56: g = {6'h1c, 6'h22, 6'h22, 6'h1c, 6'h22, 6'h22, 6'h1c};
      6'd57: g = {6'h1c, 6'h22, 6'h22, 6'h1e, 6'h02, 6'h02, 6'h1c};
      6'd58: g = {6'h00, 6'h18, 6'h18, 6'h00, 6'h18, 6'h18, 6'h00};
      6'd59: g = {6'h18, 6'h18, 6'h00, 6'h18, 6'h18, 6'h08, 6'h10};
      6'd60: g = {6'h04, 6'h08, 6'h10, 6'h20, 6'h10, 6'h08, 6'h04};
      6'd61: g = {6'h00, 6'h00, 6'h3e, 6'h00, 6'h3e, 6'h00, 6'h00};
      6'd62: g = {6'h10, 6'h08, 6'h04, 6'h02, 6'h04, 6'h08, 6'h10};
      6'd63: g = {6'h18, 6'h24, 6'h04, 6'h08, 6'h08, 6'h00, 6'h08};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: sv/vdg_front.sv
// Front end: configuration registers, input acceptance, line classification
// and the text row counters. Uses vdg_pkg.
`include "vdg_scanline_pixel_generator_top_defines.svh"

module vdg_front
  import vdg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [LINE_W-1:0]     scan_line,
  input  logic [COL_W-1:0]      group_column,
  input  logic [BYTE_W-1:0]     video_byte,
  input  logic                  q_full,
  output logic                  push,
  output vdg_item_t             push_item
);

  logic [MODE_W-1:0] video_mode_r, video_mode_nxt;
  logic              colour_set_r, colour_set_nxt;
  logic              pal_timing_r, pal_timing_nxt;
  logic [RL_W-1:0]   row_line_r, row_line_nxt;
  logic [TR_W-1:0]   text_row_r, text_row_nxt;

  logic              line_zero;
  logic              visible;
  logic              row_wrap;
  logic [RL_W-1:0]   rl_cur, rl_step;
  logic [TR_W-1:0]   tr_cur, tr_step;
  logic [LINE_W-1:0] line_inc;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // line zero restarts the counters before the group is drawn
  assign line_zero = (scan_line == '0);
  assign rl_cur    = line_zero ? '0 : row_line_r;
  assign tr_cur    = line_zero ? '0 : text_row_r;
  assign row_wrap  = (rl_cur == RL_W'(ROWS_PER_CHAR - 1));
  assign rl_step   = row_wrap ? '0 : rl_cur + RL_W'(1);
  assign tr_step   = row_wrap ? tr_cur + TR_W'(1) : tr_cur;
  assign visible   = (scan_line < LINE_W'(VISIBLE_LINES));
  assign line_inc  = scan_line + LINE_W'(1);

  always_comb begin
    push_item.visible       = visible;
    push_item.reload        = (scan_line == LINE_W'(PAL_RELOAD))
                              || (scan_line == LINE_W'(NTSC_RELOAD) && !pal_timing_r);
    push_item.vblank        = !visible && (scan_line < LINE_W'(VBLANK_END));
    push_item.mode          = video_mode_r;
    push_item.cs            = colour_set_r;
    push_item.col           = group_column;
    push_item.vbyte         = video_byte;
    push_item.row_line      = rl_cur;
    push_item.text_row_next = tr_step;
    push_item.line_next     = line_inc[LINE_NEXT_W-1:0];
  end

  always_comb begin
    video_mode_nxt = video_mode_r;
    colour_set_nxt = colour_set_r;
    pal_timing_nxt = pal_timing_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VIDEO_MODE: video_mode_nxt = cfg_wdata[MODE_W-1:0];
        CFG_COLOUR_SET: colour_set_nxt = cfg_wdata[0];
        CFG_PAL_TIMING: pal_timing_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_line_nxt = row_line_r;
    text_row_nxt = text_row_r;
    if (push) begin
      row_line_nxt = rl_cur;
      text_row_nxt = tr_cur;
      // advance after the last column of a visible text line
      if (visible && !video_mode_r[0]
          && group_column == COL_W'(GROUPS_PER_LINE - 1)) begin
        row_line_nxt = rl_step;
        text_row_nxt = tr_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_mode_r <= '0;
      colour_set_r <= 1'b0;
      pal_timing_r <= 1'b0;
      row_line_r   <= '0;
      text_row_r   <= '0;
    end else begin
      video_mode_r <= video_mode_nxt;
      colour_set_r <= colour_set_nxt;
      pal_timing_r <= pal_timing_nxt;
      row_line_r   <= row_line_nxt;
      text_row_r   <= text_row_nxt;
    end
  end

  `VDG_ASSERT_SAME(a_row_line_range, 1'b1, row_line_r < RL_W'(ROWS_PER_CHAR))

endmodule

// File: sv/vdg_queue.sv
// Short FIFO of classified groups between front and back.
// Uses vdg_pkg for the item type.
`include "vdg_scanline_pixel_generator_top_defines.svh"

module vdg_queue
  import vdg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  vdg_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output vdg_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vdg_item_t          store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  `VDG_ASSERT_SAME(a_q_no_overflow, push, !full)
  `VDG_ASSERT_SAME(a_q_no_underflow, pop, head_valid)
  `VDG_ASSERT_NEXT(a_q_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1))

endmodule

// File: sv/vdg_back.sv
// Back end: glyph lookup, pixel rendering, fetch address and the output register.
// Uses vdg_pkg for the item type, font and colour tables.
`include "vdg_scanline_pixel_generator_top_defines.svh"

module vdg_back
  import vdg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  vdg_item_t               head_item,
  output logic                    pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [NUM_PIX*PIX_W-1:0] pixels,
  output logic [ADDR_W-1:0]       fetch_address,
  output logic                    fetch_valid,
  output logic                    vblank
);

  logic                              out_valid_r, out_valid_nxt;
  logic [NUM_PIX-1:0][PIX_W-1:0]     pix_r;
  logic [ADDR_W-1:0]                 addr_r;
  logic                              fvalid_r;
  logic                              vblank_r;

  logic [NUM_PIX-1:0][PIX_W-1:0]     pix_c;
  logic [ADDR_W-1:0]                 addr_c;
  glyph_t                            glyph_all;
  logic [GLYPH_W-1:0]                glyph_row;
  logic [BYTE_W-1:0]                 glyph_bits;
  logic [1:0]                        blocks;
  logic [PIX_W-1:0]                  semi_colour;
  logic [PIX_W-1:0]                  base4;
  logic [PIX_W-1:0]                  fg;
  logic [3:0][1:0]                   pairs;
  logic [2*LINE_NEXT_W-1:0]          div3_prod;
  logic [LINE_NEXT_W-1:0]            vrow;
  logic                              wide;
  logic [ADDR_W-1:0]                 bm_addr;
  logic [ADDR_W-1:0]                 txt_addr;
  logic [ADDR_W-1:0]                 col_off;
  logic                              is_text;

  assign pop           = head_valid && (!out_valid_r || out_tready);
  assign is_text       = !head_item.mode[0];
  assign glyph_all     = font_glyph(head_item.vbyte[5:0]);
  assign semi_colour   = PIX_W'(head_item.vbyte[7:6]) + PIX_W'({head_item.cs, 2'b00})
                         + PIX_W'(1);
  assign base4         = PIX_W'({head_item.cs, 2'b00}) + PIX_W'(1);
  assign fg            = BITMAP_COLOURS[{head_item.cs, 1'b1}];
  assign div3_prod     = head_item.line_next * LINE_NEXT_W'(DIV3_MUL);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pairs[k] = head_item.vbyte[BYTE_W-1-2*k -: 2];
    end
  end

  // only the middle seven lines of the cell carry pattern
  always_comb begin
    glyph_row = '0;
    if (head_item.row_line >= RL_W'(GLYPH_FIRST_ROW)
        && head_item.row_line <= RL_W'(GLYPH_LAST_ROW)) begin
      glyph_row = glyph_all[3'(RL_W'(GLYPH_LAST_ROW) - head_item.row_line)];
    end
    glyph_bits = {2'b00, glyph_row};
  end

  // semigraphics: each third of the cell takes its own pair of block bits
  always_comb begin
    case (head_item.row_line[3:2])
      2'd0:    blocks = head_item.vbyte[5:4];
      2'd1:    blocks = head_item.vbyte[3:2];
      default: blocks = head_item.vbyte[1:0];
    endcase
  end

  // vertical repeat and bytes per line of each bitmap mode; text reads whole columns
  always_comb begin
    vrow = head_item.line_next;
    wide = 1'b1;
    if (!is_text) begin
      unique case (head_item.mode) inside
        MODE_BM4_16, MODE_BM2_16A: begin
          vrow = LINE_NEXT_W'(div3_prod[2*LINE_NEXT_W-1:DIV3_SHIFT]);
          wide = 1'b0;
        end
        MODE_BM2_16B: begin
          vrow = head_item.line_next >> 1;
          wide = 1'b0;
        end
        MODE_BM2_16C: wide = 1'b0;
        MODE_BM4_32A: vrow = LINE_NEXT_W'(div3_prod[2*LINE_NEXT_W-1:DIV3_SHIFT]);
        MODE_BM4_32B: vrow = head_item.line_next >> 1;
        default: ;
      endcase
    end
  end

  assign col_off  = wide ? ADDR_W'(head_item.col) : ADDR_W'(head_item.col >> 1);
  assign bm_addr  = SCREEN_BASE
                    + (wide ? (ADDR_W'(vrow) << 5) : (ADDR_W'(vrow) << 4))
                    + col_off;
  assign txt_addr = SCREEN_BASE + ADDR_W'({head_item.text_row_next, head_item.col});

  always_comb begin
    logic [2:0] i3;
    logic [2:0] j;
    logic       b;
    pix_c = '0;
    i3    = '0;
    j     = '0;
    b     = 1'b0;
    if (head_item.visible) begin
      for (int i = 0; i < NUM_PIX; i++) begin
        i3 = 3'(i);
        if (is_text) begin
          if (head_item.vbyte[SEMI_BIT]) begin
            b = i3[2] ? blocks[0] : blocks[1];
            pix_c[i] = b ? semi_colour : '0;
          end else begin
            b = glyph_bits[3'(7 - i)] ^ head_item.vbyte[INV_BIT];
            pix_c[i] = TEXT_COLOURS[{head_item.cs, b}];
          end
        end else begin
          unique case (head_item.mode) inside
            MODE_BM4_16: begin
              pix_c[i] = PIX_W'(pairs[{head_item.col[0], i3[2]}]) + base4;
            end
            MODE_BM2_16A, MODE_BM2_16B, MODE_BM2_16C: begin
              j = {head_item.col[0], i3[2:1]};
              pix_c[i] = head_item.vbyte[3'(7) - j] ? fg : '0;
            end
            MODE_BM4_32A, MODE_BM4_32B, MODE_BM4_32C: begin
              pix_c[i] = PIX_W'(pairs[i3[2:1]]) + base4;
            end
            default: begin
              pix_c[i] = head_item.vbyte[3'(7) - i3] ? fg : '0;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    if (head_item.visible) begin
      addr_c = is_text ? txt_addr : bm_addr;
    end else if (head_item.reload) begin
      addr_c = SCREEN_BASE + col_off;
    end else begin
      addr_c = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r    <= pix_c;
      addr_r   <= addr_c;
      fvalid_r <= head_item.visible || head_item.reload;
      vblank_r <= head_item.vblank;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign pixels        = pix_r;
  assign fetch_address = addr_r;
  assign fetch_valid   = fvalid_r;
  assign vblank        = vblank_r;

  `VDG_ASSERT_SAME(a_vblank_black, out_valid_r && vblank_r, pix_r == '0 && !fvalid_r)
  `VDG_ASSERT_NEXT(a_pop_loads_out, pop, out_valid_r)

endmodule

// File: sv/vdg_scanline_pixel_generator_top.sv
// Top level of the scanline pixel generator: stream ports, configuration port,
// and the front / queue / back chain. Uses vdg_pkg, vdg_front, vdg_queue, vdg_back.
//
// Renders one 8-pixel column group per accepted word: the word carries the scan
// line, the column (0 to 31) and the video byte, and the result word carries eight
// colour indices (0 black to 8 orange), the video address of the same column on
// the next line with its valid flag, and the vertical blank flag (lines 192 to
// 223). Even video modes draw text from the internal 64-character font (bit 7
// inverts, bit 6 picks 2x3 semigraphics); odd modes are 2- and 4-colour bitmaps
// at 16 or 32 bytes per line. Lines 192 and up are black; lines 261 (unless
// pal_timing is set) and 311 give the frame reload address. The block sustains
// one word per clock cycle while out_tready is high: the front end updates the
// text row counters in the same cycle it accepts a word, so consecutive words
// never wait on each other, and the back end does its glyph lookup and address
// arithmetic in the same cycle that loads the output register. Each result is
// held in the queue and then in the output register, which drives out_tvalid.
// A queue of QUEUE_DEPTH words sits between the two halves, so in_tready
// depends only on the queue fill and never on out_tready.
// Write configuration only while no word is in flight.
`include "vdg_scanline_pixel_generator_top_defines.svh"

module vdg_scanline_pixel_generator_top
  import vdg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: 0 video_mode, 1 colour_set, 2 pal_timing
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata from bit 0: scan_line[8:0], group_column[13:9], video_byte[21:14], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata from bit 0: pixel_0..pixel_7 (4 bits each, [31:0]),
  // fetch_address[47:32], fetch_valid[48], vblank[49], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // split the input word into its fields
  logic [LINE_W-1:0]            scan_line;
  logic [COL_W-1:0]             group_column;
  logic [BYTE_W-1:0]            video_byte;

  logic                         push;
  vdg_item_t                    push_item;
  logic                         q_full;
  logic                         pop;
  logic                         head_valid;
  vdg_item_t                    head_item;

  logic [NUM_PIX*PIX_W-1:0]     pixels;
  logic [ADDR_W-1:0]            fetch_address;
  logic                         fetch_valid;
  logic                         vblank;

  assign scan_line    = in_tdata[LINE_W-1:0];
  assign group_column = in_tdata[LINE_W+COL_W-1:LINE_W];
  assign video_byte   = in_tdata[IN_FIELDS_W-1:LINE_W+COL_W];

  // front: accept, classify, advance the text row counters
  vdg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .scan_line    (scan_line),
    .group_column (group_column),
    .video_byte   (video_byte),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // hold classified words while the output side stalls
  vdg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: render pixels and the next-line address into the output register
  vdg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .pixels        (pixels),
    .fetch_address (fetch_address),
    .fetch_valid   (fetch_valid),
    .vblank        (vblank)
  );

  // pack the result word, zero pad on top
  assign out_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), vblank, fetch_valid,
                      fetch_address, pixels};

endmodule

// File: test/scanline_check_pkg.sv
// Expected-result model and result checker for the scanline pixel generator testbench.
// Depends on vdg_pkg for field widths, mode codes, register indexes and frame geometry.
package scanline_check_pkg;
  import vdg_pkg::*;

  // bit positions inside out_tdata
  localparam int ADDR_LSB   = NUM_PIX * PIX_W;
  localparam int FETCH_BIT  = ADDR_LSB + ADDR_W;
  localparam int VBLANK_BIT = FETCH_BIT + 1;

  // register index that maps to no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [PIX_W-1:0] TEXT_INK   [4] = '{4'd0, 4'd1, 4'd0, 4'd8};
  localparam logic [PIX_W-1:0] BITMAP_INK [4] = '{4'd0, 4'd1, 4'd0, 4'd5};

  // character cells are 12 lines; only lines 3..9 carry pattern rows
  localparam int FONT_TOP    = 3;
  localparam int FONT_HEIGHT = 7;

  localparam logic [5:0] FONT_ROWS [64 * FONT_HEIGHT] = '{
    6'h1c,6'h22,6'h02,6'h1a,6'h2a,6'h2a,6'h1c, 6'h08,6'h14,6'h22,6'h22,6'h3e,6'h22,6'h22,
    6'h3c,6'h12,6'h12,6'h1c,6'h12,6'h12,6'h3c, 6'h1c,6'h22,6'h20,6'h20,6'h20,6'h22,6'h1c,
    6'h3c,6'h12,6'h12,6'h12,6'h12,6'h12,6'h3c, 6'h3e,6'h20,6'h20,6'h3c,6'h20,6'h20,6'h3e,
    6'h3e,6'h20,6'h20,6'h3c,6'h20,6'h20,6'h20, 6'h1e,6'h20,6'h20,6'h26,6'h22,6'h22,6'h1e,
    6'h22,6'h22,6'h22,6'h3e,6'h22,6'h22,6'h22, 6'h1c,6'h08,6'h08,6'h08,6'h08,6'h08,6'h1c,
    6'h02,6'h02,6'h02,6'h02,6'h22,6'h22,6'h1c, 6'h22,6'h24,6'h28,6'h30,6'h28,6'h24,6'h22,
    6'h20,6'h20,6'h20,6'h20,6'h20,6'h20,6'h3e, 6'h22,6'h36,6'h2a,6'h2a,6'h22,6'h22,6'h22,
    6'h22,6'h32,6'h2a,6'h26,6'h22,6'h22,6'h22, 6'h3e,6'h22,6'h22,6'h22,6'h22,6'h22,6'h3e,
    6'h3c,6'h22,6'h22,6'h3c,6'h20,6'h20,6'h20, 6'h1c,6'h22,6'h22,6'h22,6'h2a,6'h24,6'h1a,
    6'h3c,6'h22,6'h22,6'h3c,6'h28,6'h24,6'h22, 6'h1c,6'h22,6'h10,6'h08,6'h04,6'h22,6'h1c,
    6'h3e,6'h08,6'h08,6'h08,6'h08,6'h08,6'h08, 6'h22,6'h22,6'h22,6'h22,6'h22,6'h22,6'h1c,
    6'h22,6'h22,6'h22,6'h14,6'h14,6'h08,6'h08, 6'h22,6'h22,6'h22,6'h2a,6'h2a,6'h36,6'h22,
    6'h22,6'h22,6'h14,6'h08,6'h14,6'h22,6'h22, 6'h22,6'h22,6'h14,6'h08,6'h08,6'h08,6'h08,
    6'h3e,6'h02,6'h04,6'h08,6'h10,6'h20,6'h3e, 6'h38,6'h20,6'h20,6'h20,6'h20,6'h20,6'h38,
    6'h20,6'h20,6'h10,6'h08,6'h04,6'h02,6'h02, 6'h0e,6'h02,6'h02,6'h02,6'h02,6'h02,6'h0e,
    6'h08,6'h1c,6'h2a,6'h08,6'h08,6'h08,6'h08, 6'h00,6'h08,6'h10,6'h3e,6'h10,6'h08,6'h00,
    6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00, 6'h08,6'h08,6'h08,6'h08,6'h08,6'h00,6'h08,
    6'h14,6'h14,6'h14,6'h00,6'h00,6'h00,6'h00, 6'h14,6'h14,6'h36,6'h00,6'h36,6'h14,6'h14,
    6'h08,6'h1e,6'h20,6'h1c,6'h02,6'h3c,6'h08, 6'h32,6'h32,6'h04,6'h08,6'h10,6'h26,6'h26,
    6'h10,6'h28,6'h28,6'h10,6'h2a,6'h24,6'h1a, 6'h18,6'h18,6'h18,6'h00,6'h00,6'h00,6'h00,
    6'h08,6'h10,6'h20,6'h20,6'h20,6'h10,6'h08, 6'h08,6'h04,6'h02,6'h02,6'h02,6'h04,6'h08,
    6'h00,6'h08,6'h1c,6'h3e,6'h1c,6'h08,6'h00, 6'h00,6'h08,6'h08,6'h3e,6'h08,6'h08,6'h00,
    6'h00,6'h00,6'h00,6'h30,6'h30,6'h10,6'h20, 6'h00,6'h00,6'h00,6'h3e,6'h00,6'h00,6'h00,
    6'h00,6'h00,6'h00,6'h00,6'h00,6'h30,6'h30, 6'h02,6'h02,6'h04,6'h08,6'h10,6'h20,6'h20,
    6'h18,6'h24,6'h24,6'h24,6'h24,6'h24,6'h18, 6'h08,6'h18,6'h08,6'h08,6'h08,6'h08,6'h1c,
    6'h1c,6'h22,6'h02,6'h1c,6'h20,6'h20,6'h3e, 6'h1c,6'h22,6'h02,6'h0c,6'h02,6'h22,6'h1c,
    6'h04,6'h0c,6'h14,6'h3e,6'h04,6'h04,6'h04, 6'h3e,6'h20,6'h3c,6'h02,6'h02,6'h22,6'h1c,
    6'h1c,6'h20,6'h20,6'h3c,6'h22,6'h22,6'h1c, 6'h3e,6'h02,6'h04,6'h08,6'h10,6'h20,6'h20,
    6'h1c,6'h22,6'h22,6'h1c,6'h22,6'h22,6'h1c, 6'h1c,6'h22,6'h22,6'h1e,6'h02,6'h02,6'h1c,
    6'h00,6'h18,6'h18,6'h00,6'h18,6'h18,6'h00, 6'h18,6'h18,6'h00,6'h18,6'h18,6'h08,6'h10,
    6'h04,6'h08,6'h10,6'h20,6'h10,6'h08,6'h04, 6'h00,6'h00,6'h3e,6'h00,6'h3e,6'h00,6'h00,
    6'h10,6'h08,6'h04,6'h02,6'h04,6'h08,6'h10, 6'h18,6'h24,6'h04,6'h08,6'h08,6'h00,6'h08
  };

  typedef struct packed {
    logic [LINE_W-1:0]             line;
    logic [COL_W-1:0]              col;
    logic [NUM_PIX-1:0][PIX_W-1:0] pix;
    logic [ADDR_W-1:0]             addr;
    logic                          fetch_ok;
    logic                          vblank;
  } group_result_t;

  // 16-byte modes fetch one byte per two columns
  function automatic bit narrow_mode(input logic [MODE_W-1:0] m);
    return m == MODE_BM4_16 || m == MODE_BM2_16A || m == MODE_BM2_16B || m == MODE_BM2_16C;
  endfunction

  // bitmap row reached after n display lines
  function automatic int bitmap_row(input int n, input logic [MODE_W-1:0] m);
    case (m)
      MODE_BM4_16, MODE_BM2_16A, MODE_BM4_32A: return n / 3;
      MODE_BM2_16B, MODE_BM4_32B: return n / 2;
      default: return n;
    endcase
  endfunction

  class scanline_checker;
    logic [MODE_W-1:0] mode = '0;
    logic              cs = 1'b0;
    logic              pal = 1'b0;
    logic [RL_W-1:0]   row_line = '0;
    logic [TR_W-1:0]   text_row = '0;
    group_result_t     pending_groups[$];
    int                errors = 0;
    int                checked = 0;

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIDEO_MODE: mode = data;
        CFG_COLOUR_SET: cs = data[0];
        CFG_PAL_TIMING: pal = data[0];
        default: ;
      endcase
    endfunction

    // work out the result of one accepted group and queue it
    function void expect_group(input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col,
                               input logic [BYTE_W-1:0] vb);
      group_result_t r;
      int n, v, sh, blocks, ink, glyph, b, p, i;
      logic [PIX_W-1:0] fg, bg;
      logic [RL_W-1:0] nrl;
      logic [TR_W-1:0] ntr;
      r = '0;
      r.line = line;
      r.col = col;
      v = int'(vb);
      if (line == 0) begin
        row_line = '0;
        text_row = '0;
      end
      r.vblank = (line >= VISIBLE_LINES) && (line < VBLANK_END);
      fg = BITMAP_INK[{cs, 1'b1}];
      bg = BITMAP_INK[{cs, 1'b0}];
      if (line < VISIBLE_LINES) begin
        n = int'(line) + 1;
        r.fetch_ok = 1'b1;
        if (!mode[0]) begin
          if (vb[SEMI_BIT]) begin
            // 2x3 blocks: upper, middle, lower third of the cell pick a bit pair
            sh = int'(row_line >> 2) * 2;
            blocks = ((v << sh) >> 4) & 3;
            ink = (v >> 6) + 4 * int'(cs) + 1;
            for (i = 0; i < 4; i++) begin
              r.pix[i] = blocks[1] ? PIX_W'(ink) : '0;
              r.pix[i + 4] = blocks[0] ? PIX_W'(ink) : '0;
            end
          end else begin
            glyph = (row_line >= FONT_TOP && row_line < FONT_TOP + FONT_HEIGHT) ?
                    int'(FONT_ROWS[int'(vb[5:0]) * FONT_HEIGHT + int'(row_line) - FONT_TOP]) : 0;
            for (i = 0; i < NUM_PIX; i++) begin
              b = ((glyph >> (7 - i)) & 1) ^ int'(vb[INV_BIT]);
              r.pix[i] = TEXT_INK[{cs, b[0]}];
            end
          end
          // the next-line address already uses the stepped counters
          nrl = row_line + RL_W'(1);
          ntr = text_row;
          if (nrl >= ROWS_PER_CHAR) begin
            nrl = '0;
            ntr = ntr + TR_W'(1);
          end
          r.addr = SCREEN_BASE + ADDR_W'({ntr, col});
          if (col == GROUPS_PER_LINE - 1) begin
            row_line = nrl;
            text_row = ntr;
          end
        end else begin
          for (i = 0; i < NUM_PIX; i++) begin
            case (mode)
              MODE_BM4_16: begin
                p = (v >> (6 - 2 * (2 * int'(col[0]) + i / 4))) & 3;
                r.pix[i] = PIX_W'(p + 4 * int'(cs) + 1);
              end
              MODE_BM4_32A, MODE_BM4_32B, MODE_BM4_32C: begin
                p = (v >> (6 - 2 * (i / 2))) & 3;
                r.pix[i] = PIX_W'(p + 4 * int'(cs) + 1);
              end
              MODE_BM2_16A, MODE_BM2_16B, MODE_BM2_16C: begin
                b = (v >> (7 - (4 * int'(col[0]) + i / 2))) & 1;
                r.pix[i] = b[0] ? fg : bg;
              end
              default: begin
                b = (v >> (7 - i)) & 1;
                r.pix[i] = b[0] ? fg : bg;
              end
            endcase
          end
          if (narrow_mode(mode))
            r.addr = ADDR_W'(int'(SCREEN_BASE) + bitmap_row(n, mode) * 16 + int'(col) / 2);
          else
            r.addr = ADDR_W'(int'(SCREEN_BASE) + bitmap_row(n, mode) * 32 + int'(col));
        end
      end else if ((line == NTSC_RELOAD && !pal) || line == PAL_RELOAD) begin
        r.fetch_ok = 1'b1;
        r.addr = narrow_mode(mode) ? SCREEN_BASE + ADDR_W'(col >> 1) : SCREEN_BASE + ADDR_W'(col);
      end
      pending_groups.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // compare one accepted result word with the oldest expectation
    task check_group(input logic [OUT_DATA_W-1:0] w);
      group_result_t e;
      int i;
      checked++;
      if (pending_groups.size() == 0) begin
        report($sformatf("result %0h arrived with nothing expected", w));
        return;
      end
      e = pending_groups.pop_front();
      for (i = 0; i < NUM_PIX; i++)
        if (w[i * PIX_W +: PIX_W] !== e.pix[i])
          report($sformatf("line %0d col %0d pixel_%0d: got %0d, want %0d",
                           e.line, e.col, i, w[i * PIX_W +: PIX_W], e.pix[i]));
      if (w[ADDR_LSB +: ADDR_W] !== e.addr)
        report($sformatf("line %0d col %0d fetch_address: got %h, want %h",
                         e.line, e.col, w[ADDR_LSB +: ADDR_W], e.addr));
      if (w[FETCH_BIT] !== e.fetch_ok)
        report($sformatf("line %0d col %0d fetch_valid: got %b, want %b",
                         e.line, e.col, w[FETCH_BIT], e.fetch_ok));
      if (w[VBLANK_BIT] !== e.vblank)
        report($sformatf("line %0d col %0d vblank: got %b, want %b",
                         e.line, e.col, w[VBLANK_BIT], e.vblank));
    endtask
  endclass

endpackage

// File: test/tb_top.sv
// Self-checking testbench for vdg_scanline_pixel_generator_top.
// Depends on vdg_pkg and scanline_check_pkg; drives directed and random column groups.
module tb_top;
  import vdg_pkg::*;
  import scanline_check_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_GROUPS = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // scan_line[8:0], group_column[13:9], video_byte[21:14], zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pixel_0..pixel_7 [31:0], fetch_address[47:32], fetch_valid[48], vblank[49], zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  scanline_checker sb;
  bit calm = 1'b0;          // suppress idling on both sides
  int cycles = 0;
  int groups_sent = 0;
  int settings_used = 0;

  vdg_scanline_pixel_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // idle with a chance of 23 in a hundred on each side unless calm
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  // result side: check every accepted word, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_group(out_tdata);
    out_tready <= !idle_now();
  end

  // hard stop if the block hangs
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Offer one word and hold it until accepted. Valid stays high into the next
  // call; an idle gap drops it in a fresh clock step, never in the accept step.
  task automatic send_group(input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col,
                            input logic [BYTE_W-1:0] vb);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({vb, col, line});
    do @(posedge clk); while (!in_tready);
    sb.expect_group(line, col, vb);
    groups_sent++;
  endtask

  // Hold the sender until every expected word is back, then let the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_groups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Rewrite all registers while idle. Upper data bits of the one-bit registers
  // are random and must be ignored; now and then hit the unused index too.
  task automatic configure(input logic [MODE_W-1:0] mode, input logic cs, input logic pal);
    drain();
    write_reg(CFG_VIDEO_MODE, mode);
    write_reg(CFG_COLOUR_SET, {3'($urandom), cs});
    write_reg(CFG_PAL_TIMING, {3'($urandom), pal});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Walk scan lines in order. Visible lines get a few random columns and
  // mostly column 31, which steps the text row counters; now and then a full
  // line. Blanking lines get a single group. Sprinkle in noise words anywhere in
  // the 9-bit line range. With skip_blank the walk jumps from line 191 back to
  // line 1, so the text row counter runs past 31 and wraps.
  task automatic run_lines(input int first, input int count, input bit skip_blank);
    int line, extra, k;
    line = first;
    repeat (count) begin
      if (line < VISIBLE_LINES) begin
        if (!skip_blank && $urandom_range(0, 23) == 0) begin
          for (k = 0; k < GROUPS_PER_LINE; k++)
            send_group(LINE_W'(line), COL_W'(k), BYTE_W'($urandom));
        end else begin
          extra = $urandom_range(0, skip_blank ? 1 : 3);
          repeat (extra) send_group(LINE_W'(line), COL_W'($urandom), BYTE_W'($urandom));
          if ($urandom_range(0, 15) != 0)
            send_group(LINE_W'(line), COL_W'(GROUPS_PER_LINE - 1), BYTE_W'($urandom));
        end
      end else begin
        send_group(LINE_W'(line),
                   ($urandom_range(0, 3) == 0) ? COL_W'(GROUPS_PER_LINE - 1) : COL_W'($urandom),
                   BYTE_W'($urandom));
      end
      if ($urandom_range(0, 9) == 0)
        send_group(LINE_W'($urandom), COL_W'($urandom), BYTE_W'($urandom));
      if (skip_blank)
        line = (line >= VISIBLE_LINES - 1) ? 1 : line + 1;
      else if ($urandom_range(0, 39) == 0)
        line = $urandom_range(0, PAL_RELOAD);
      else
        line = (line >= PAL_RELOAD) ? 0 : line + 1;
    end
  endtask

  initial begin
    int first_random, phase;
    logic [MODE_W-1:0] pick;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Text mode, colour set 0, NTSC: line zero clear, plain, inverse and
    // semigraphic bytes, last visible line, blanking edges, both reload lines,
    // lines past the frame up to the field maximum.
    configure(4'd0, 1'b0, 1'b0);
    send_group(9'd0, 5'd0, 8'h00);
    send_group(9'd0, 5'd1, 8'h80);
    send_group(9'd0, 5'd2, 8'h40);
    send_group(9'd0, 5'd3, 8'hFF);
    send_group(9'd0, 5'd31, 8'h3F);
    send_group(9'd191, 5'd31, 8'h7F);
    send_group(9'd192, 5'd0, 8'h55);
    send_group(9'd223, 5'd1, 8'hAA);
    send_group(9'd224, 5'd2, 8'h11);
    send_group(9'd261, 5'd3, 8'h22);
    send_group(9'd311, 5'd31, 8'h33);
    send_group(9'd312, 5'd4, 8'h44);
    send_group(9'd511, 5'd31, 8'hFF);

    // Widest bitmap mode, colour set 1, PAL: line 261 must not reload.
    configure(MODE_BM2_32, 1'b1, 1'b1);
    send_group(9'd0, 5'd0, 8'hA5);
    send_group(9'd100, 5'd31, 8'h5A);
    send_group(9'd261, 5'd7, 8'h00);
    send_group(9'd311, 5'd30, 8'hFF);

    // Every remaining bitmap mode once, odd column so the low half shows.
    configure(MODE_BM4_16, 1'b0, 1'b0);
    send_group(9'd10, 5'd1, 8'hE4);
    configure(MODE_BM2_16A, 1'b1, 1'b0);
    send_group(9'd30, 5'd3, 8'hE4);
    configure(MODE_BM4_32A, 1'b0, 1'b0);
    send_group(9'd50, 5'd5, 8'hE4);
    configure(MODE_BM2_16B, 1'b1, 1'b0);
    send_group(9'd70, 5'd7, 8'hE4);
    configure(MODE_BM4_32B, 1'b0, 1'b0);
    send_group(9'd90, 5'd9, 8'hE4);
    configure(MODE_BM2_16C, 1'b1, 1'b0);
    send_group(9'd110, 5'd11, 8'hE4);
    configure(MODE_BM4_32C, 1'b0, 1'b0);
    send_group(9'd130, 5'd13, 8'hE4);

    // Random phases: new settings each time, mostly frame walks from line zero.
    // Phase 2 is the text row wrap walk; phase 3 runs with no idling at all.
    first_random = groups_sent;
    phase = 0;
    while (groups_sent - first_random < RANDOM_GROUPS) begin
      phase++;
      pick = MODE_W'($urandom);
      if (phase == 2 || $urandom_range(0, 1) == 0) pick[0] = 1'b0;
      configure(pick, 1'($urandom), 1'($urandom));
      calm = (phase == 3);
      if (phase == 2)
        run_lines(1, 400, 1'b1);
      else
        run_lines(($urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, PAL_RELOAD),
                  $urandom_range(30, 200), 1'b0);
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d groups under %0d register settings, all modes and frame regions,",
             groups_sent, settings_used);
    $display("including a text row wrap walk; %0d results checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_groups.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
